>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Holds the controller state encoding, status codes, config indexes and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int HEAP_BYTES_DEF = 1048576;
	localparam int AW = 21;

	// status codes
	localparam logic [1:0] ST_ALLOC   = 2'd0;
	localparam logic [1:0] ST_FREED   = 2'd1;
	localparam logic [1:0] ST_OOM     = 2'd2;
	localparam logic [1:0] ST_BADADDR = 2'd3;

	// config register indexes
	localparam logic [1:0] CFG_PAGE_SHIFT = 2'd0;
	localparam logic [1:0] CFG_HEADER     = 2'd1;
	localparam logic [1:0] CFG_LIMIT      = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_GROW,
		S_SPLIT,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input word, reset walk
		logic rd;       // issue descriptor read at cursor
		logic step;     // advance cursor to next
		logic grow;     // append new block
		logic take;     // take cursor block (split when allowed)
		logic res_free; // free hit at cursor
		logic set_res;  // write result register
		logic [1:0] res_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free_op;
		logic null_addr;
		logic walk_end;
		logic hit;
		logic grow_ok;
	} sts_t;

endpackage

>>> design/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl: controller of the allocator
// Sequences the list walk, growth, split and result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_busy,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::cmd_t  cmd,
	output logic            idle
);
	import ffba_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.is_free_op && sts.null_addr) begin
					cmd.res_status = ST_BADADDR;
					state_d = S_DONE;
				end else if (sts.walk_end) begin
					if (sts.is_free_op) begin
						cmd.res_status = ST_BADADDR;
						state_d = S_DONE;
					end else state_d = S_GROW;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.hit) begin
					if (sts.is_free_op) begin
						cmd.res_free = 1'b1;
						cmd.res_status = ST_FREED;
						state_d = S_DONE;
					end else state_d = S_SPLIT;
				end else begin
					cmd.step = 1'b1;
					state_d = S_READ;
				end
			end
			S_GROW: begin
				if (sts.grow_ok) begin
					cmd.grow = 1'b1;
					state_d = S_SPLIT;
				end else begin
					cmd.res_status = ST_OOM;
					state_d = S_DONE;
				end
			end
			S_SPLIT: begin
				cmd.take = 1'b1;
				cmd.res_status = ST_ALLOC;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.set_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// status for done carried in register inside datapath
		if (state_q == S_DONE) cmd.res_status = ST_ALLOC;
	end

endmodule

>>> design/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp: datapath of the allocator
// Descriptor memory, walk cursor, growth arithmetic and split logic.
// ----------------------------------------------------------------------------
module ffba_dp #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ffba_pkg::cmd_t           cmd,
	input  logic                     in_action,
	input  logic [20:0]              in_req,
	input  logic [20:0]              in_addr,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [20:0]              cfg_data,
	output ffba_pkg::sts_t           sts,
	output logic [20:0]              res_addr,
	output logic [1:0]               res_status
);
	import ffba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [22:0] HEAP_LIM = 23'(HEAP_BYTES > 2097151 ? 2097151 : HEAP_BYTES);

	// descriptor memory, one read port registered
	logic [20:0] mem_start [MAX_BLOCKS];
	logic [20:0] mem_size  [MAX_BLOCKS];
	logic        mem_free  [MAX_BLOCKS];
	logic [IW-1:0] mem_next [MAX_BLOCKS];

	logic [4:0]  page_shift_q;
	logic [6:0]  header_q;
	logic [20:0] limit_q;
	logic [CW-1:0] count_q, steps_q;
	logic [IW-1:0] tail_q, cur_q;
	logic [20:0] brk_q;
	logic        action_q;
	logic [21:0] req_q;     // rounded request, may reach 2^21
	logic [20:0] addr_q;
	logic [20:0] rd_start_q, rd_size_q;
	logic        rd_free_q;
	logic [IW-1:0] rd_next_q;
	logic [1:0]  pend_status_q;
	logic [20:0] pend_addr_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= 5'd12;
			header_q <= 7'd24;
			limit_q <= 21'd1048576;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PAGE_SHIFT: page_shift_q <= cfg_data[4:0];
				CFG_HEADER:     header_q <= cfg_data[6:0];
				CFG_LIMIT:      limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// growth arithmetic: total = (needed/page + 1) * page
	logic [22:0] needed, total, limit_min, brk_sum;
	logic [22:0] page_mask;
	logic        big_page;
	always_comb begin
		needed = 23'(req_q) + 23'(header_q);
		big_page = page_shift_q > 5'd22;
		page_mask = big_page ? '1 : ((23'd1 << page_shift_q) - 23'd1);
		total = big_page ? 23'h7FFFFF : ((needed & ~page_mask) + page_mask + 23'd1);
		limit_min = (23'(limit_q) < HEAP_LIM) ? 23'(limit_q) : HEAP_LIM;
		brk_sum = 23'(brk_q) + total;
	end
	// big page always fails: total exceeds any limit
	logic grow_fit;
	assign grow_fit = !big_page && !(total > limit_min) && !(brk_sum > limit_min);

	// split test on the read descriptor
	logic [22:0] split_need;
	logic        can_split;
	assign split_need = 23'(req_q) + 23'(header_q) + 23'd1;
	assign can_split = (23'(rd_size_q) > split_need) && (count_q < CW'(MAX_BLOCKS));

	// status
	assign sts.is_free_op = action_q;
	assign sts.null_addr  = (addr_q == '0);
	assign sts.walk_end   = (steps_q >= count_q);
	assign sts.hit = action_q ? (rd_start_q == addr_q)
	                          : (rd_free_q && (22'(rd_size_q) >= req_q));
	assign sts.grow_ok = grow_fit && (count_q < CW'(MAX_BLOCKS));

	// rounded request and split fields
	logic [21:0] req_round;
	assign req_round = (22'(in_req) + 22'd7) & ~22'd7;
	logic [IW-1:0] new_idx;
	assign new_idx = count_q[IW-1:0];

	// memory writes and reads, plus read-back of a grown block descriptor
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_start_q <= mem_start[cur_q];
			rd_size_q  <= mem_size[cur_q];
			rd_free_q  <= mem_free[cur_q];
			rd_next_q  <= mem_next[cur_q];
		end
		if (cmd.res_free) mem_free[cur_q] <= 1'b1;
		if (cmd.grow) begin
			mem_start[new_idx] <= 21'(23'(brk_q) + 23'(header_q));
			mem_size[new_idx]  <= 21'(total - 23'(header_q));
			mem_free[new_idx]  <= 1'b1;
			mem_next[new_idx]  <= '0;
			if (count_q != '0) mem_next[tail_q] <= new_idx;
			rd_start_q <= 21'(23'(brk_q) + 23'(header_q));
			rd_size_q  <= 21'(total - 23'(header_q));
			rd_next_q  <= '0;
			rd_free_q  <= 1'b1;
		end
		if (cmd.take) begin
			mem_free[cur_q] <= 1'b0;
			if (can_split) begin
				mem_start[new_idx] <= 21'(23'(rd_start_q) + 23'(req_q) + 23'(header_q));
				mem_size[new_idx]  <= 21'(23'(rd_size_q) - 23'(req_q) - 23'(header_q));
				mem_free[new_idx]  <= 1'b1;
				mem_next[new_idx]  <= rd_next_q;
				mem_size[cur_q]    <= req_q[20:0];
				mem_next[cur_q]    <= new_idx;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			req_q <= req_round;
			addr_q <= in_addr;
		end
	end

	// walk control and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tail_q <= '0;
			brk_q <= '0;
			steps_q <= '0;
			cur_q <= '0;
			pend_status_q <= ST_ALLOC;
			pend_addr_q <= '0;
			res_status <= ST_ALLOC;
			res_addr <= '0;
		end else begin
			if (cmd.load) begin
				steps_q <= '0;
				cur_q <= '0;
			end
			if (cmd.step) begin
				steps_q <= steps_q + 1'b1;
				cur_q <= rd_next_q;
			end
			if (cmd.grow) begin
				cur_q <= new_idx;
				tail_q <= new_idx;
				count_q <= count_q + 1'b1;
				brk_q <= brk_sum[20:0];
			end
			if (cmd.take) begin
				if (can_split) begin
					count_q <= count_q + 1'b1;
					if (tail_q == cur_q) tail_q <= new_idx;
				end
				pend_status_q <= ST_ALLOC;
				pend_addr_q <= rd_start_q;
			end
			if (cmd.res_free || (!cmd.take && !cmd.set_res && (cmd.res_status != ST_ALLOC))) begin
				pend_status_q <= cmd.res_status;
				pend_addr_q <= '0;
			end
			if (cmd.set_res) begin
				res_status <= pend_status_q;
				res_addr <= pend_addr_q;
			end
		end
	end

endmodule

>>> design/first_fit_block_allocator.sv
// One word is handled at a time: a new word is taken only while idle. The walk
// reads one descriptor after another, each through a READ and a CHECK state,
// from the single-port descriptor memory. Output register frees the core early.
// Reset: arst_n clears list count, tail, heap break and config to defaults;
// descriptor memory contents are undefined until written.
// ----------------------------------------------------------------------------
// first_fit_block_allocator: top level
// First-fit heap allocator with split, page-granular heap growth.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // action[0], req_bytes[21:1], block_addr[42:22]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // granted_addr[20:0], status[22:21]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [20:0] cfg_data
);
	import ffba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle, in_fire, out_q;
	logic [20:0] res_addr;
	logic [1:0] res_status;

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;

	ffba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_q && !m_tready), .sts(sts), .cmd(cmd), .idle(idle)
	);

	ffba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEAP_BYTES(HEAP_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_action(s_tdata[0]), .in_req(s_tdata[21:1]), .in_addr(s_tdata[42:22]),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.sts(sts), .res_addr(res_addr), .res_status(res_status)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= 1'b0;
		else if (cmd.set_res) out_q <= 1'b1;
		else if (m_tready) out_q <= 1'b0;
	end

	assign m_tvalid = out_q;
	assign m_tdata = {1'b0, res_status, res_addr};

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_res |-> !(out_q && !m_tready)) else $error("result overwritten");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.grow && cmd.take)) else $error("grow and take together");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !idle) else $error("accept did not start walk");
`endif

endmodule

>>> bench/tb_first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator: self-checking bench for the block allocator
// Drives allocate/free words with random gaps and output stalls, predicts
// each granted address and status from a local descriptor list model, and
// compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;

	localparam int NBLK = 64;
	localparam int HEAP = 1048576;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [20:0] addr;
		logic [1:0]  status;
	} alloc_result_t;

	// Descriptor-list predictor plus queue of pending results.
	class alloc_scoreboard;
		logic [20:0] blk_start[NBLK];
		logic [20:0] blk_size[NBLK];
		bit          blk_free[NBLK];
		int          blk_next[NBLK];
		int          blk_count;
		int          tail;
		longint      brk;
		int          pg_shift;
		int          hdr;
		longint      limit;
		alloc_result_t pending[$];
		int          errors;
		int          n_alloc, n_free, n_oom, n_bad;

		function void clear();
			blk_count = 0; tail = 0; brk = 0;
			pg_shift = 12; hdr = 24; limit = 1048576;
			pending.delete();
		endfunction

		function void set_reg(logic [1:0] idx, logic [20:0] val);
			if (idx == CFG_PAGE_SHIFT) pg_shift = val[4:0];
			else if (idx == CFG_HEADER) hdr = val[6:0];
			else if (idx == CFG_LIMIT) limit = val;
		endfunction

		function void take(int i, longint req);
			int n;
			if (longint'(blk_size[i]) > req + hdr + 1 && blk_count < NBLK) begin
				n = blk_count;
				blk_start[n] = 21'(longint'(blk_start[i]) + req + hdr);
				blk_size[n] = 21'(longint'(blk_size[i]) - req - hdr);
				blk_free[n] = 1;
				blk_next[n] = blk_next[i];
				blk_size[i] = 21'(req);
				blk_next[i] = n;
				if (tail == i) tail = n;
				blk_count = n + 1;
			end
			blk_free[i] = 0;
		endfunction

		// Note an accepted request and queue its expected result.
		function void note_request(logic act, logic [20:0] req_b, logic [20:0] baddr);
			alloc_result_t r;
			longint req, pg, total, lim;
			int i, n;
			bit done;
			r.addr = '0;
			done = 0;
			if (act == ACT_FREE) begin
				r.status = ST_BADADDR;
				if (baddr != 0) begin
					i = 0;
					for (int s = 0; s < blk_count && !done; s++) begin
						if (blk_start[i] == baddr) begin
							blk_free[i] = 1; r.status = ST_FREED; done = 1;
						end else i = blk_next[i] % NBLK;
					end
				end
				if (done) n_free++; else n_bad++;
			end else begin
				req = (longint'(req_b) + 7) & ~longint'(7);
				i = 0;
				for (int s = 0; s < blk_count && !done; s++) begin
					if (blk_free[i] && longint'(blk_size[i]) >= req) begin
						take(i, req);
						r.addr = blk_start[i]; r.status = ST_ALLOC; done = 1;
					end else i = blk_next[i] % NBLK;
				end
				if (!done) begin
					pg = longint'(1) << pg_shift;
					total = ((req + hdr) / pg + 1) * pg;
					lim = limit < HEAP ? limit : HEAP;
					if (brk + total > lim || blk_count >= NBLK) begin
						r.status = ST_OOM;
					end else begin
						n = blk_count;
						blk_start[n] = 21'(brk + hdr);
						blk_size[n] = 21'(total - hdr);
						blk_free[n] = 1;
						blk_next[n] = 0;
						if (n > 0) blk_next[tail] = n;
						tail = n;
						blk_count = n + 1;
						brk = (brk + total) & 64'h1FFFFF;
						take(n, req);
						r.addr = blk_start[n]; r.status = ST_ALLOC;
					end
				end
				if (r.status == ST_OOM) n_oom++; else n_alloc++;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [20:0] got_addr, logic [1:0] got_st);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word: granted_addr %0d status %0d",
					got_addr, got_st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got_addr !== e.addr) begin
				$error("granted_addr: expected %0d, got %0d", e.addr, got_addr);
				errors++;
			end
			if (got_st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got_st);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_idx = '0;
	logic [20:0] cfg_data = '0;

	alloc_scoreboard sb;
	int  send_idle_pct, recv_idle_pct;
	int  hold_off_cycles;
	int  quiet_cycles;
	int  n_sent;

	always #6 clk = ~clk;

	first_fit_block_allocator dut (.*);

	// Live start addresses, used to aim free requests at real blocks.
	logic [20:0] live_addrs[$];

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata[0], s_tdata[21:1], s_tdata[42:22]);
				if (!s_tdata[0] && sb.pending[$].status == ST_ALLOC)
					live_addrs.push_back(sb.pending[$].addr);
			end
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[20:0], m_tdata[22:21]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
	end

	// Receiver stalls, including long hold-offs counted here.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stall watchdog.
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Ready only moves at the rising edge, so checking it at the falling
	// edge tells whether the next rising edge accepts the word.
	task automatic send_word(logic act, logic [20:0] req_b, logic [20:0] baddr);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'b0, baddr, req_b, act};
		while (!s_tready) @(negedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [20:0] val);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		sb.set_reg(idx, val);
	endtask

	// Wait until every expected result has come back, plus latency margin.
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (140) @(negedge clk);
	endtask

	// Mostly realistic sizes, sometimes extremes and bit-wide values.
	function automatic logic [20:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 21'($urandom_range(256));
		if (r < 85) return 21'($urandom_range(8192));
		if (r < 95) return 21'($urandom);
		return 21'(r[0] ? 21'h1FFFFF : 21'h100000);
	endfunction

	task automatic random_phase(int count);
		logic [20:0] a;
		int k;
		for (int j = 0; j < count; j++) begin
			if (live_addrs.size() > 0 && $urandom_range(99) < 40) begin
				k = $urandom_range(live_addrs.size() - 1);
				a = live_addrs[k];
				if ($urandom_range(3) != 0) live_addrs.delete(k);
				send_word(ACT_FREE, 21'($urandom), a);
			end else if ($urandom_range(99) < 8) begin
				send_word(ACT_FREE, 21'($urandom), 21'($urandom));
			end else begin
				send_word(ACT_ALLOC, pick_size(), 21'($urandom));
			end
		end
	endtask

	// Change the config without a reset: drain, then reprogram; the heap list stays.
	task automatic set_all(int ps, int hb, int lim);
		drain();
		write_reg(CFG_PAGE_SHIFT, 21'(ps));
		write_reg(CFG_HEADER, 21'(hb));
		write_reg(CFG_LIMIT, 21'(lim));
		cfg_we <= 0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		sb.errors = 0;
		send_idle_pct = 0; recv_idle_pct = 0; hold_off_cycles = 0;
		quiet_cycles = 0; n_sent = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: defaults, zero request, nulls, unknown free, extremes.
		send_word(ACT_FREE, 21'd0, 21'd0);
		send_word(ACT_FREE, 21'd0, 21'd24);
		send_word(ACT_ALLOC, 21'd0, 21'd0);
		send_word(ACT_ALLOC, 21'd1, 21'd0);
		send_word(ACT_ALLOC, 21'd100, 21'h1FFFFF);
		send_word(ACT_FREE, 21'd0, 21'd24);
		send_word(ACT_FREE, 21'd0, 21'd24);
		send_word(ACT_ALLOC, 21'd3, 21'd0);
		send_word(ACT_ALLOC, 21'h1FFFFF, 21'd0);
		send_word(ACT_ALLOC, 21'h100000, 21'd0);
		send_word(ACT_FREE, 21'h1FFFFF, 21'h1FFFFF);
		send_word(ACT_ALLOC, 21'd5000, 21'd0);
		// Zero header, 64-byte pages, limit of 64 bytes.
		set_all(6, 0, 64);
		send_word(ACT_ALLOC, 21'd0, 21'd0);
		send_word(ACT_ALLOC, 21'd8, 21'd0);
		send_word(ACT_ALLOC, 21'd64, 21'd0);
		// 64 KiB pages and 64-byte header; then largest header, out-of-range page shift and limit.
		set_all(16, 64, 1048576);
		send_word(ACT_ALLOC, 21'd65000, 21'd0);
		set_all(31, 127, 21'h1FFFFF);
		send_word(ACT_ALLOC, 21'd10, 21'd0);
		set_all(12, 24, 1048576);

		// Random phase 1: sender idles lightly, receiver often, one long hold-off.
		send_idle_pct = 10; recv_idle_pct = 51;
		hold_off_cycles = 3000;
		random_phase(500);
		set_all(6, 8, 1048576);
		// Phase 2: swapped idling; tiny pages fill the descriptor table.
		send_idle_pct = 51; recv_idle_pct = 10;
		random_phase(500);
		set_all(9, 0, 300000);
		// Phase 3: full rate.
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(530);

		drain();
		$display("covered %0d requests: %0d allocs, %0d frees, %0d out of memory, %0d bad frees",
			n_sent, sb.n_alloc, sb.n_free, sb.n_oom, sb.n_bad);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
